// ===== src/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg: shared types and constants of the 3x3 matrix inverse
// Fixed-point format, widths of the intermediate values and the divider depth.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ENT_W = 32;
	// Cofactor: difference of two 32x32 products.
	localparam int COF_W = 65;
	// Determinant: sum of three 32x65 products.
	localparam int DET_W = 99;
	localparam int DMAG_W = 98;
	// Cofactor magnitude, then shifted left by 2*FRAC_BITS.
	localparam int CMAG_W = 64;
	localparam int NUM_W = CMAG_W + 2 * FRAC_BITS;
	// Quotient bits kept: beyond this the result saturates anyway.
	localparam int Q_W = 33;
	localparam int THR_W = 31;

	typedef logic signed [ENT_W-1:0] ent_t;
	typedef logic signed [COF_W-1:0] cof_t;

	// Divider lane state carried from stage to stage.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DMAG_W:0] rem;
		logic [Q_W-1:0] quo;
		logic ovf;
		logic neg;
	} div_lane_t;

endpackage

// ===== src/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse: pipelined 3x3 fixed-point matrix inverse
// Adjugate divided by the determinant, Q16.16 in and out, saturated.
// ----------------------------------------------------------------------------
// Usage: one matrix enters per s_tvalid/s_tready transaction on the slave
// stream, nine signed Q16.16 entries packed row-major in s_tdata (r0c0 in the
// lowest bits). The result leaves on the master stream: nine saturated Q16.16
// entries in m_tdata, and m_tuser flags a singular matrix (entries then zero).
// Stages: cofactor products, cofactors, determinant products, determinant
// sum, magnitude and threshold check, then one stage per quotient bit in nine
// parallel dividers (33 stages), then the saturating output register.
// Throughput is one matrix per cycle unless the output is blocked. The user
// must write det_threshold through cfg_valid/cfg_ready only while the block
// is idle; the block does not enforce this. It resets to 1. Reset clears all
// valid bits; payload is not reset. When the receiver holds m_tready low
// while the output register holds an untaken result, the whole pipeline
// freezes and s_tready drops with it; in every other cycle s_tready is high.
// ----------------------------------------------------------------------------
module matrix3x3_inverse
	import m3inv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [THR_W-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [9*ENT_W-1:0] s_tdata,   // in_r0c0 .. in_r2c2, lowest first
	output logic m_tvalid,
	input  logic m_tready,
	output logic [9*ENT_W-1:0] m_tdata,   // out_r0c0 .. out_r2c2, lowest first
	output logic m_tuser                  // singular
);

	localparam int NSTG = 6 + Q_W;

	logic [THR_W-1:0] thr_q;
	logic [NSTG-1:0] vld_q;
	logic adv;

	// Configuration register.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= {{(THR_W - 1){1'b0}}, 1'b1};
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Whole pipeline moves together; it holds only when the output is blocked.
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], s_tvalid};
		end
	end

	// Stage 1: the eighteen cofactor products.
	ent_t m [9];
	logic signed [2*ENT_W-1:0] pa_s1 [9], pb_s1 [9];
	ent_t m_s1 [9];
	localparam int IA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int IB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int IC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int ID [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
	for (genvar k = 0; k < 9; k++) begin : g_in
		assign m[k] = s_tdata[k*ENT_W +: ENT_W];
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s1[k] <= m[IA[k]] * m[IB[k]];
				pb_s1[k] <= m[IC[k]] * m[ID[k]];
				m_s1[k] <= m[k];
			end
		end
	end

	// Stage 2: cofactors.
	cof_t adj_s2 [9];
	ent_t m_s2 [3];
	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (adv) begin
				adj_s2[k] <= COF_W'(pa_s1[k]) - COF_W'(pb_s1[k]);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0] <= m_s1[0];
			m_s2[1] <= m_s1[1];
			m_s2[2] <= m_s1[2];
		end
	end

	// Stage 3: first-row expansion products, split as 32 x 33 and 32 x 32.
	localparam int LO_W = 32;
	logic signed [ENT_W+COF_W-LO_W-1:0] dph_s3 [3];
	logic signed [ENT_W+LO_W:0] dpl_s3 [3];
	cof_t adj_s3 [9];
	localparam int IE [3] = '{0, 3, 6};
	for (genvar k = 0; k < 3; k++) begin : g_dp
		always_ff @(posedge clk) begin
			if (adv) begin
				dph_s3[k] <= m_s2[k] * $signed(adj_s2[IE[k]][COF_W-1:LO_W]);
				dpl_s3[k] <= m_s2[k] * $signed({1'b0, adj_s2[IE[k]][LO_W-1:0]});
			end
		end
	end
	for (genvar k = 0; k < 9; k++) begin : g_a3
		always_ff @(posedge clk) begin
			if (adv) adj_s3[k] <= adj_s2[k];
		end
	end

	// Stage 4: determinant.
	logic signed [DET_W-1:0] det_s4;
	cof_t adj_s4 [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= (DET_W'(dph_s3[0]) <<< LO_W) + (DET_W'(dph_s3[1]) <<< LO_W)
				+ (DET_W'(dph_s3[2]) <<< LO_W)
				+ DET_W'($signed(dpl_s3[0])) + DET_W'($signed(dpl_s3[1]))
				+ DET_W'($signed(dpl_s3[2]));
		end
	end
	for (genvar k = 0; k < 9; k++) begin : g_a4
		always_ff @(posedge clk) begin
			if (adv) adj_s4[k] <= adj_s3[k];
		end
	end

	// Stage 5: magnitudes and singular check.
	logic [DMAG_W-1:0] dmag_s5;
	logic dneg_s5, sing_s5;
	logic [CMAG_W-1:0] cmag_s5 [9];
	logic cneg_s5 [9];
	logic [DET_W-1:0] dabs;
	assign dabs = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
	always_ff @(posedge clk) begin
		if (adv) begin
			dmag_s5 <= dabs[DMAG_W-1:0];
			dneg_s5 <= det_s4[DET_W-1];
			sing_s5 <= (dabs >> (2 * FRAC_BITS)) <= DET_W'(thr_q);
		end
	end
	for (genvar k = 0; k < 9; k++) begin : g_cm
		logic [COF_W-1:0] ca;
		assign ca = adj_s4[k][COF_W-1] ? COF_W'(-adj_s4[k]) : COF_W'(adj_s4[k]);
		always_ff @(posedge clk) begin
			if (adv) begin
				cmag_s5[k] <= ca[CMAG_W-1:0];
				cneg_s5[k] <= adj_s4[k][COF_W-1];
			end
		end
	end

	// Singular flag follows the divider pipeline.
	logic [Q_W-1:0] sing_q;
	always_ff @(posedge clk) begin
		if (adv) sing_q <= {sing_q[Q_W-2:0], sing_s5};
	end

	// Divider lanes and the saturating output register.
	logic [ENT_W-1:0] res_q [9];
	logic sing_out_q;
	for (genvar k = 0; k < 9; k++) begin : g_div
		logic [Q_W-1:0] quo;
		logic ovf, sgn;
		logic [ENT_W-1:0] r;
		m3inv_div u_div (
			.clk(clk), .en(adv),
			.cmag(cmag_s5[k]), .neg(cneg_s5[k] ^ dneg_s5), .dmag(dmag_s5),
			.quo(quo), .ovf(ovf), .sign(sgn)
		);
		always_comb begin
			if (sgn) begin
				if (ovf || quo > Q_W'(33'h080000000)) r = 32'h80000000;
				else r = ENT_W'(-quo);
			end else begin
				if (ovf || quo > Q_W'(33'h07FFFFFFF)) r = 32'h7FFFFFFF;
				else r = quo[ENT_W-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) res_q[k] <= sing_q[Q_W-1] ? '0 : r;
		end
		assign m_tdata[k*ENT_W +: ENT_W] = res_q[k];
	end
	always_ff @(posedge clk) begin
		if (adv) sing_out_q <= sing_q[Q_W-1];
	end
	assign m_tuser = sing_out_q;

endmodule

// ===== src/m3inv_div.sv =====
// ----------------------------------------------------------------------------
// m3inv_div: pipelined restoring divider lane
// One quotient bit per stage. Leading dividend bits that cannot produce
// quotient bits below Q_W are folded into the remainder before the first stage;
// any set quotient bit above Q_W is detected as overflow.
// ----------------------------------------------------------------------------
module m3inv_div
	import m3inv_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  logic [CMAG_W-1:0] cmag,
	input  logic neg,
	input  logic [DMAG_W-1:0] dmag,
	output logic [Q_W-1:0] quo,
	output logic ovf,
	output logic sign
);

	localparam int HI_W = NUM_W - Q_W;

	div_lane_t lane0;
	div_lane_t lane_s [1:Q_W];
	logic [DMAG_W-1:0] den_s [1:Q_W-1];
	logic [NUM_W-1:0] num0;

	// High part of the dividend: if it reaches the divisor, the quotient overflows.
	assign num0 = {cmag, {(2 * FRAC_BITS){1'b0}}};
	always_comb begin
		lane0.num = num0;
		lane0.rem = {{(DMAG_W + 1 - HI_W){1'b0}}, num0[NUM_W-1:Q_W]};
		lane0.quo = '0;
		lane0.ovf = ({{(DMAG_W + 1 - HI_W){1'b0}}, num0[NUM_W-1:Q_W]}
			>= {1'b0, dmag});
		lane0.neg = neg;
	end

	// One compare and subtract per register stage.
	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		div_lane_t cur;
		logic [DMAG_W-1:0] den;
		logic [DMAG_W:0] trial;
		logic take;
		div_lane_t nxt;
		if (i == 0) begin : g_first
			assign cur = lane0;
			assign den = dmag;
		end else begin : g_next
			assign cur = lane_s[i];
			assign den = den_s[i];
		end
		always_comb begin
			trial = {cur.rem[DMAG_W-1:0], cur.num[Q_W-1-i]};
			take = trial >= {1'b0, den};
			nxt = cur;
			nxt.rem = take ? trial - {1'b0, den} : trial;
			nxt.quo = {cur.quo[Q_W-2:0], take};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[i+1] <= nxt;
			end
		end
		// The divisor travels only as far as a later stage needs it.
		if (i < Q_W - 1) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[i+1] <= den;
				end
			end
		end
	end

	assign quo = lane_s[Q_W].quo;
	assign ovf = lane_s[Q_W].ovf;
	assign sign = lane_s[Q_W].neg;

endmodule
